// File: design/opsig_pkg.sv
// ----------------------------------------------------------------------------
// opsig_pkg
// Shared types and constants for the version 4 signature packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package opsig_pkg;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 160;

	localparam logic [17:0] MIN_SIG_LEN      = 18'd10;
	localparam logic [7:0]  LEN_TWO_BYTE     = 8'd192;
	localparam logic [7:0]  LEN_FIVE_BYTE    = 8'd255;
	localparam logic [7:0]  ISSUER_SP_TYPE   = 8'd16;
	localparam logic [15:0] ISSUER_MIN_LEN   = 16'd9;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT       = 3'd1,
		ST_HASHED_OVR  = 3'd2,
		ST_UNHASH_OVR  = 3'd3,
		ST_SCAN_FAIL   = 3'd4
	} opsig_status_t;

	typedef struct packed {
		logic        first_byte;
		logic [7:0]  data_byte;
		logic [17:0] sig_len;
	} opsig_item_t;

	typedef struct packed {
		logic [63:0]   issuer_id;
		logic [15:0]   hash_check;
		logic [15:0]   unhashed_len;
		logic [15:0]   hashed_len;
		logic [7:0]    hash_algo;
		logic [7:0]    pubkey_algo;
		logic [7:0]    sig_type;
		logic [17:0]   bytes_read;
		opsig_status_t status;
	} opsig_result_t;

endpackage

`default_nettype wire

// File: design/opsig_core.sv
// ----------------------------------------------------------------------------
// opsig_core
// Packet state, area counters and issuer subpacket scanner; one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module opsig_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    step,
	input  wire opsig_pkg::opsig_item_t  item,
	output logic                         res_valid,
	output opsig_pkg::opsig_result_t     res
);
	import opsig_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_PUBKEY, P_DIGEST, P_HLEN_HI, P_HLEN_LO, P_HASHED,
		P_ULEN_HI, P_ULEN_LO, P_UNHASHED, P_CHECK_HI, P_CHECK_LO
	} phase_t;

	typedef enum logic [2:0] {
		S_LEN0, S_LEN1, S_LEN4, S_TYPE, S_BODY, S_ID, S_FOUND, S_FAILED
	} scan_t;

	phase_t      phase_q, phase_d;
	scan_t       scan_q, scan_d;
	logic [17:0] pkt_len_q, pkt_len_d;
	logic [15:0] hcount_q, hcount_d;
	logic [15:0] ucount_q, ucount_d;
	logic [23:0] hdr_q, hdr_d;
	logic [15:0] hlen_q, hlen_d;
	logic [15:0] ulen_q, ulen_d;
	logic [7:0]  chk_hi_q, chk_hi_d;
	logic [15:0] skip_q, skip_d;
	logic [31:0] len4_q, len4_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [63:0] shift_q, shift_d;

	function automatic logic len_ok(input logic [31:0] len, input logic [15:0] rem);
		len_ok = (len != 32'd0) && (len <= {16'd0, rem});
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic [15:0] rem;
		logic [15:0] len1;
		logic [31:0] len4_n;
		logic [15:0] hlen_n;
		logic [15:0] ulen_n;
		logic [17:0] total;
		b      = item.data_byte;
		rem    = ucount_q - 16'd1;
		len1   = {skip_q[7:0] - LEN_TWO_BYTE, 8'h00} + {8'h00, b} + {8'h00, LEN_TWO_BYTE};
		len4_n = {len4_q[23:0], b};
		hlen_n = {hlen_q[15:8], b};
		ulen_n = {ulen_q[15:8], b};
		total  = {2'b00, hlen_q} + {2'b00, ulen_n} + MIN_SIG_LEN;

		phase_d   = phase_q;
		scan_d    = scan_q;
		pkt_len_d = pkt_len_q;
		hcount_d  = hcount_q;
		ucount_d  = ucount_q;
		hdr_d     = hdr_q;
		hlen_d    = hlen_q;
		ulen_d    = ulen_q;
		chk_hi_d  = chk_hi_q;
		skip_d    = skip_q;
		len4_d    = len4_q;
		cnt_d     = cnt_q;
		shift_d   = shift_q;

		res_valid        = 1'b0;
		res.status       = ST_OK;
		res.bytes_read   = 18'd0;
		res.sig_type     = hdr_q[23:16];
		res.pubkey_algo  = hdr_q[15:8];
		res.hash_algo    = hdr_q[7:0];
		res.hashed_len   = hlen_q;
		res.unhashed_len = ulen_q;
		res.hash_check   = 16'd0;
		res.issuer_id    = (scan_q == S_FOUND) ? shift_q : 64'd0;

		if (step) begin
			if (item.first_byte) begin
				scan_d    = S_LEN0;
				pkt_len_d = item.sig_len;
				hcount_d  = 16'd0;
				ucount_d  = 16'd0;
				hlen_d    = 16'd0;
				ulen_d    = 16'd0;
				chk_hi_d  = 8'd0;
				skip_d    = 16'd0;
				len4_d    = 32'd0;
				cnt_d     = 3'd0;
				shift_d   = 64'd0;
				if (item.sig_len < MIN_SIG_LEN) begin
					hdr_d            = 24'd0;
					phase_d          = P_IDLE;
					res_valid        = 1'b1;
					res.status       = ST_SHORT;
					res.sig_type     = 8'd0;
					res.pubkey_algo  = 8'd0;
					res.hash_algo    = 8'd0;
					res.hashed_len   = 16'd0;
					res.unhashed_len = 16'd0;
					res.issuer_id    = 64'd0;
				end else begin
					hdr_d   = {b, 16'd0};
					phase_d = P_PUBKEY;
				end
			end else begin
				case (phase_q)
					P_PUBKEY: begin
						hdr_d   = {hdr_q[23:16], b, 8'd0};
						phase_d = P_DIGEST;
					end
					P_DIGEST: begin
						hdr_d   = {hdr_q[23:8], b};
						phase_d = P_HLEN_HI;
					end
					P_HLEN_HI: begin
						hlen_d  = {b, 8'd0};
						phase_d = P_HLEN_LO;
					end
					P_HLEN_LO: begin
						hlen_d = hlen_n;
						if ({2'b00, hlen_n} + MIN_SIG_LEN > pkt_len_q) begin
							phase_d          = P_IDLE;
							res_valid        = 1'b1;
							res.status       = ST_HASHED_OVR;
							res.hashed_len   = hlen_n;
						end else begin
							hcount_d = hlen_n;
							phase_d  = (hlen_n != 16'd0) ? P_HASHED : P_ULEN_HI;
						end
					end
					P_HASHED: begin
						hcount_d = hcount_q - 16'd1;
						if (hcount_q == 16'd1)
							phase_d = P_ULEN_HI;
					end
					P_ULEN_HI: begin
						ulen_d  = {b, 8'd0};
						phase_d = P_ULEN_LO;
					end
					P_ULEN_LO: begin
						ulen_d = ulen_n;
						if (total > pkt_len_q) begin
							phase_d          = P_IDLE;
							res_valid        = 1'b1;
							res.status       = ST_UNHASH_OVR;
							res.unhashed_len = ulen_n;
						end else begin
							ucount_d = ulen_n;
							scan_d   = (ulen_n != 16'd0) ? S_LEN0 : S_FAILED;
							phase_d  = (ulen_n != 16'd0) ? P_UNHASHED : P_CHECK_HI;
						end
					end
					P_UNHASHED: begin
						ucount_d = rem;
						case (scan_q)
							S_LEN0: begin
								if (b < LEN_TWO_BYTE) begin
									if (len_ok({24'd0, b}, rem)) begin
										skip_d = {8'd0, b};
										scan_d = S_TYPE;
									end else begin
										scan_d = S_FAILED;
									end
								end else if (b != LEN_FIVE_BYTE) begin
									skip_d = {8'd0, b};
									scan_d = S_LEN1;
								end else begin
									len4_d = 32'd0;
									cnt_d  = 3'd0;
									scan_d = S_LEN4;
								end
							end
							S_LEN1: begin
								if (len_ok({16'd0, len1}, rem)) begin
									skip_d = len1;
									scan_d = S_TYPE;
								end else begin
									scan_d = S_FAILED;
								end
							end
							S_LEN4: begin
								len4_d = len4_n;
								cnt_d  = cnt_q + 3'd1;
								if (cnt_q == 3'd3) begin
									if (len_ok(len4_n, rem)) begin
										skip_d = len4_n[15:0];
										scan_d = S_TYPE;
									end else begin
										scan_d = S_FAILED;
									end
								end
							end
							S_TYPE: begin
								if (b == ISSUER_SP_TYPE) begin
									if (skip_q < ISSUER_MIN_LEN) begin
										scan_d = S_FAILED;
									end else begin
										shift_d = 64'd0;
										cnt_d   = 3'd0;
										scan_d  = S_ID;
									end
								end else begin
									skip_d = skip_q - 16'd1;
									scan_d = (skip_q != 16'd1) ? S_BODY : S_LEN0;
								end
							end
							S_BODY: begin
								skip_d = skip_q - 16'd1;
								if (skip_q == 16'd1)
									scan_d = S_LEN0;
							end
							S_ID: begin
								shift_d = {shift_q[55:0], b};
								cnt_d   = cnt_q + 3'd1;
								if (cnt_q == 3'd7)
									scan_d = S_FOUND;
							end
							default: begin
							end
						endcase
						if (rem == 16'd0 && scan_d != S_FOUND)
							scan_d = S_FAILED;
						if (rem == 16'd0)
							phase_d = P_CHECK_HI;
					end
					P_CHECK_HI: begin
						chk_hi_d = b;
						phase_d  = P_CHECK_LO;
					end
					P_CHECK_LO: begin
						phase_d        = P_IDLE;
						res_valid      = 1'b1;
						res.hash_check = {chk_hi_q, b};
						if (scan_q == S_FOUND) begin
							res.status     = ST_OK;
							res.bytes_read = {2'b00, hlen_q} + {2'b00, ulen_q} + MIN_SIG_LEN;
						end else begin
							res.status = ST_SCAN_FAIL;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			scan_q  <= S_LEN0;
		end else begin
			phase_q <= phase_d;
			scan_q  <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		pkt_len_q <= pkt_len_d;
		hcount_q  <= hcount_d;
		ucount_q  <= ucount_d;
		hdr_q     <= hdr_d;
		hlen_q    <= hlen_d;
		ulen_q    <= ulen_d;
		chk_hi_q  <= chk_hi_d;
		skip_q    <= skip_d;
		len4_q    <= len4_d;
		cnt_q     <= cnt_d;
		shift_q   <= shift_d;
	end

	a_result_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step)
		else $error("result raised without a step");

	a_fail_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ST_OK) |-> res.bytes_read == 18'd0)
		else $error("failure result carries a byte count");

	a_ok_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_OK) |-> (phase_q == P_CHECK_LO && scan_q == S_FOUND))
		else $error("ok result outside the hash-check byte");

endmodule

`default_nettype wire

// File: design/openpgp_sig_v4_parser.sv
// ----------------------------------------------------------------------------
// openpgp_sig_v4_parser
// Version 4 signature packet parser with issuer key ID capture.
// ----------------------------------------------------------------------------
// Input words carry the packet bytes that follow the version byte, one byte
// per word; tuser marks the first byte of a packet and sig_len is sampled with
// it. A first-byte word always restarts the parse; other words while idle are
// dropped. At most one result word is produced per packet: on the first byte
// for a packet under 10 bytes, on the second length byte of an area that
// overruns the packet, otherwise on the second hash-check byte.
// A word is registered in the input register on accept and is processed by
// the core once the output register can advance; its result is registered
// in the output register, which drives m_axis_tvalid.
// Throughput: one word per cycle while the output side takes results; the
// parse state is updated once for each word processed.
// Reset clears the parse state and both valid flags; no result is pending.
// When the receiver stalls with a result waiting, the input register holds
// its word and tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module openpgp_sig_v4_parser (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// data_byte[7:0], sig_len[25:8], zero fill
	input  wire logic [opsig_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// first_byte[0]
	input  wire logic                               s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// status[2:0], bytes_read[20:3], sig_type[28:21], pubkey_algo[36:29],
	// hash_algo[44:37], hashed_len[60:45], unhashed_len[76:61],
	// hash_check[92:77], issuer_id[156:93], zero fill
	output logic [opsig_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
	import opsig_pkg::*;

	logic          in_valid_s1;
	opsig_item_t   item_s1;
	logic          advance;
	logic          step;
	logic          res_valid;
	opsig_result_t res;
	logic          out_valid_q;
	opsig_result_t out_q;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !in_valid_s1 || advance;
	assign step          = in_valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				in_valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.first_byte <= s_axis_tuser;
			item_s1.data_byte  <= s_axis_tdata[7:0];
			item_s1.sig_len    <= s_axis_tdata[25:8];
		end
		if (step && res_valid)
			out_q <= res;
	end

	opsig_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - $bits(opsig_result_t))'(0), out_q};

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");

	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid) |=> m_axis_tvalid)
		else $error("result lost between core and output register");

	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> (in_valid_s1 && $stable(item_s1)))
		else $error("held input word changed during stall");

endmodule

`default_nettype wire

// File: tb/openpgp_sig_v4_parser_tb.sv
// ----------------------------------------------------------------------------
// openpgp_sig_v4_parser_tb
// Self-checking bench for the version 4 signature packet parser. A queue of
// packet bytes is built up front: a few boundary packets, then random
// packets, many well formed with an issuer, the rest short, overrunning,
// abandoned midway or carrying broken unhashed areas. A clocked driver offers
// the bytes with random gaps. Each accepted word is run through a local parse
// model, and the monitor compares every result word field by field against
// the oldest prediction. The receiver also stalls at random, holds off once
// for a long stretch, and the sender waits twice for all results to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module openpgp_sig_v4_parser_tb;
	import opsig_pkg::*;

	localparam int WORDS_TARGET = 1150;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_LEN     = 300;
	localparam int QUIET_FROM   = 900;
	localparam int QUIET_TO     = 1300;
	localparam int TAIL_CYCLES  = 20;
	localparam int MAX_SHOWN    = 10;
	localparam int RES_W        = $bits(opsig_result_t);

	typedef enum logic [3:0] {
		PH_IDLE, PH_PUBKEY, PH_DIGEST, PH_HLEN_HI, PH_HLEN_LO, PH_HASHED,
		PH_ULEN_HI, PH_ULEN_LO, PH_UNHASHED, PH_CHECK_HI, PH_CHECK_LO
	} parse_phase_t;

	typedef enum logic [3:0] {
		SC_LEN0, SC_LEN1, SC_LEN4, SC_TYPE, SC_BODY, SC_ID, SC_FOUND, SC_FAILED
	} scan_state_t;

	typedef enum int {
		PK_NORMAL, PK_SHORT, PK_HASHED_OVR, PK_UNHASH_OVR, PK_ABANDON
	} pkt_kind_t;

	typedef enum int {
		AK_GOOD, AK_NOISE, AK_ZERO, AK_LONG, AK_CUT, AK_SHORT_ISSUER,
		AK_NO_ISSUER, AK_EMPTY
	} area_kind_t;

	typedef enum int {LF_ONE, LF_TWO, LF_FIVE} len_form_t;

	typedef struct {
		logic [7:0]  data;
		logic        first;
		logic [17:0] len;
		bit          wait_drain;
	} byte_word_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  s_valid = 1'b0;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	wire                   s_ready;
	wire                   m_valid;
	logic                  m_ready = 1'b0;
	wire  [OUT_DATA_W-1:0] m_tdata;

	openpgp_sig_v4_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (s_tdata),
		.s_axis_tuser (s_tuser),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	int cyc = 0;
	int hold_left = 0;
	int mismatches = 0;
	int stim_count = 0;
	wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

	always @(posedge clk) cyc <= cyc + 1;

	byte_word_t    tx_words[$];
	byte_word_t    pkt_words[$];
	logic [7:0]    area_bytes[$];
	opsig_result_t predicted_results[$];

	// parse model state
	parse_phase_t ph;
	scan_state_t  scan;
	logic [17:0]  pkt_len;
	logic [15:0]  hashed_left, unhashed_left, area_h, area_u, chk;
	logic [23:0]  hdr;
	logic [31:0]  skip, len_acc;
	logic [63:0]  id_acc;
	logic [3:0]   nbytes;

	function automatic void reset_parse();
		ph = PH_IDLE;
		scan = SC_LEN0;
		pkt_len = '0;
		hashed_left = '0;
		unhashed_left = '0;
		area_h = '0;
		area_u = '0;
		chk = '0;
		hdr = '0;
		skip = '0;
		len_acc = '0;
		id_acc = '0;
		nbytes = '0;
	endfunction

	function automatic opsig_result_t make_result(input opsig_status_t st,
			input logic [17:0] rd);
		opsig_result_t r;
		r.status = st;
		r.bytes_read = rd;
		r.sig_type = hdr[23:16];
		r.pubkey_algo = hdr[15:8];
		r.hash_algo = hdr[7:0];
		r.hashed_len = area_h;
		r.unhashed_len = area_u;
		r.hash_check = chk;
		r.issuer_id = (scan == SC_FOUND) ? id_acc : 64'd0;
		return r;
	endfunction

	function automatic void take_len(input logic [31:0] n, input logic [15:0] left);
		if (n == 0 || n > {16'd0, left}) begin
			scan = SC_FAILED;
		end else begin
			skip = n;
			scan = SC_TYPE;
		end
	endfunction

	function automatic void scan_step(input logic [7:0] b, input logic [15:0] left);
		case (scan)
			SC_LEN0: begin
				if (b < LEN_TWO_BYTE) begin
					take_len({24'd0, b}, left);
				end else if (b < LEN_FIVE_BYTE) begin
					skip = {24'd0, b};
					scan = SC_LEN1;
				end else begin
					len_acc = '0;
					nbytes = '0;
					scan = SC_LEN4;
				end
			end
			SC_LEN1: begin
				take_len(((skip - {24'd0, LEN_TWO_BYTE}) << 8) + {24'd0, b}
					+ {24'd0, LEN_TWO_BYTE}, left);
			end
			SC_LEN4: begin
				len_acc = {len_acc[23:0], b};
				nbytes = nbytes + 4'd1;
				if (nbytes >= 4'd4) take_len(len_acc, left);
			end
			SC_TYPE: begin
				if (b == ISSUER_SP_TYPE) begin
					if (skip < {16'd0, ISSUER_MIN_LEN}) begin
						scan = SC_FAILED;
					end else begin
						id_acc = '0;
						nbytes = '0;
						scan = SC_ID;
					end
				end else begin
					skip = skip - 32'd1;
					scan = (skip != 0) ? SC_BODY : SC_LEN0;
				end
			end
			SC_BODY: begin
				skip = skip - 32'd1;
				if (skip == 0) scan = SC_LEN0;
			end
			SC_ID: begin
				id_acc = {id_acc[55:0], b};
				nbytes = nbytes + 4'd1;
				if (nbytes >= 4'd8) scan = SC_FOUND;
			end
			default: ;
		endcase
		if (left == 0 && scan != SC_FOUND) scan = SC_FAILED;
	endfunction

	function automatic bit parse_word(input logic [7:0] b, input logic first,
			input logic [17:0] n, output opsig_result_t res);
		logic [31:0] total;
		res = '0;
		if (first) begin
			reset_parse();
			pkt_len = n;
			hdr = {b, 16'd0};
			if (pkt_len < MIN_SIG_LEN) begin
				hdr = '0;
				res = make_result(ST_SHORT, '0);
				return 1'b1;
			end
			ph = PH_PUBKEY;
			return 1'b0;
		end
		total = {16'd0, area_h} + {16'd0, area_u} + 32'(MIN_SIG_LEN);
		case (ph)
			PH_PUBKEY: begin
				hdr[15:8] = b;
				ph = PH_DIGEST;
			end
			PH_DIGEST: begin
				hdr[7:0] = b;
				ph = PH_HLEN_HI;
			end
			PH_HLEN_HI: begin
				area_h = {b, 8'd0};
				ph = PH_HLEN_LO;
			end
			PH_HLEN_LO: begin
				area_h[7:0] = b;
				if ({16'd0, area_h} + 32'(MIN_SIG_LEN) > {14'd0, pkt_len}) begin
					res = make_result(ST_HASHED_OVR, '0);
					ph = PH_IDLE;
					return 1'b1;
				end
				hashed_left = area_h;
				ph = (area_h != 0) ? PH_HASHED : PH_ULEN_HI;
			end
			PH_HASHED: begin
				hashed_left = hashed_left - 16'd1;
				if (hashed_left == 0) ph = PH_ULEN_HI;
			end
			PH_ULEN_HI: begin
				area_u = {b, 8'd0};
				ph = PH_ULEN_LO;
			end
			PH_ULEN_LO: begin
				area_u[7:0] = b;
				total = {16'd0, area_h} + {16'd0, area_u} + 32'(MIN_SIG_LEN);
				if (total > {14'd0, pkt_len}) begin
					res = make_result(ST_UNHASH_OVR, '0);
					ph = PH_IDLE;
					return 1'b1;
				end
				unhashed_left = area_u;
				scan = (area_u != 0) ? SC_LEN0 : SC_FAILED;
				ph = (area_u != 0) ? PH_UNHASHED : PH_CHECK_HI;
			end
			PH_UNHASHED: begin
				unhashed_left = unhashed_left - 16'd1;
				scan_step(b, unhashed_left);
				if (unhashed_left == 0) ph = PH_CHECK_HI;
			end
			PH_CHECK_HI: begin
				chk = {b, 8'd0};
				ph = PH_CHECK_LO;
			end
			PH_CHECK_LO: begin
				chk[7:0] = b;
				ph = PH_IDLE;
				if (scan == SC_FOUND)
					res = make_result(ST_OK, total[17:0]);
				else
					res = make_result(ST_SCAN_FAIL, '0);
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// stimulus building
	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_word(input logic [7:0] b, input logic first, input logic [17:0] n);
		byte_word_t w;
		w.data = b;
		w.first = first;
		w.len = n;
		w.wait_drain = 1'b0;
		pkt_words.push_back(w);
	endtask

	task automatic add_body(input logic [7:0] b);
		add_word(b, 1'b0, 18'($urandom_range(0, 18'h3FFFF)));
	endtask

	task automatic commit(input int unsigned n, input bit counted, input bit drain);
		byte_word_t w;
		for (int i = 0; i < n; i++) begin
			w = pkt_words[i];
			w.wait_drain = drain && (i == 0);
			tx_words.push_back(w);
		end
		if (counted) stim_count += n;
		pkt_words.delete();
	endtask

	task automatic push_len(input int unsigned n, input len_form_t form);
		int unsigned t;
		t = n - 192;
		case (form)
			LF_ONE: area_bytes.push_back(n[7:0]);
			LF_TWO: begin
				area_bytes.push_back(8'(t >> 8) + LEN_TWO_BYTE);
				area_bytes.push_back(t[7:0]);
			end
			default: begin
				area_bytes.push_back(LEN_FIVE_BYTE);
				area_bytes.push_back(n[31:24]);
				area_bytes.push_back(n[23:16]);
				area_bytes.push_back(n[15:8]);
				area_bytes.push_back(n[7:0]);
			end
		endcase
	endtask

	task automatic add_filler();
		int unsigned r, n;
		logic [7:0] t8;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			n = $urandom_range(192, 230);
			push_len(n, LF_TWO);
		end else begin
			n = (r < 5) ? 191 : $urandom_range(1, 8);
			push_len(n, ($urandom_range(0, 3) == 0) ? LF_FIVE : LF_ONE);
		end
		t8 = rnd8();
		if (t8 == ISSUER_SP_TYPE) t8 = t8 + 8'd1;
		area_bytes.push_back(t8);
		repeat (n - 1) area_bytes.push_back(rnd8());
	endtask

	task automatic add_issuer(input int unsigned n);
		push_len(n, ($urandom_range(0, 2) == 0) ? LF_FIVE : LF_ONE);
		area_bytes.push_back(ISSUER_SP_TYPE);
		repeat (n - 1) area_bytes.push_back(rnd8());
	endtask

	task automatic build_area(input area_kind_t ak);
		int unsigned tail, n;
		len_form_t form;
		case (ak)
			AK_GOOD: begin
				repeat ($urandom_range(0, 3)) add_filler();
				add_issuer($urandom_range(ISSUER_MIN_LEN, ISSUER_MIN_LEN + 3));
				repeat ($urandom_range(0, 3)) area_bytes.push_back(rnd8());
			end
			AK_NOISE: repeat ($urandom_range(1, 30)) area_bytes.push_back(rnd8());
			AK_ZERO: begin
				repeat ($urandom_range(0, 1)) add_filler();
				area_bytes.push_back(8'd0);
				repeat ($urandom_range(0, 4)) area_bytes.push_back(rnd8());
			end
			AK_LONG: begin
				repeat ($urandom_range(0, 1)) add_filler();
				tail = $urandom_range(0, 4);
				form = len_form_t'($urandom_range(0, 2));
				case (form)
					LF_ONE: n = $urandom_range(tail + 1, 191);
					LF_TWO: n = $urandom_range(192, 16319);
					default: begin
						n = $urandom();
						if (n <= tail) n = 32'hFFFF_FFFF;
					end
				endcase
				push_len(n, form);
				repeat (tail) area_bytes.push_back(rnd8());
			end
			AK_CUT: begin
				repeat ($urandom_range(0, 2)) add_filler();
				if ($urandom_range(0, 1) == 0) begin
					area_bytes.push_back(8'($urandom_range(192, 254)));
				end else begin
					area_bytes.push_back(LEN_FIVE_BYTE);
					repeat ($urandom_range(0, 3)) area_bytes.push_back(rnd8());
				end
			end
			AK_SHORT_ISSUER: begin
				repeat ($urandom_range(0, 1)) add_filler();
				add_issuer($urandom_range(1, ISSUER_MIN_LEN - 1));
			end
			AK_NO_ISSUER: repeat ($urandom_range(1, 4)) add_filler();
			default: ;
		endcase
	endtask

	task automatic gen_packet(input pkt_kind_t pk, input area_kind_t ak, input bit drain);
		int unsigned h, u, need;
		logic [17:0] sl;
		h = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 320) : $urandom_range(0, 12);
		area_bytes.delete();
		build_area(ak);
		u = area_bytes.size();
		need = MIN_SIG_LEN + h + u;
		case ($urandom_range(0, 2))
			0: sl = 18'(need);
			1: sl = 18'($urandom_range(need, need + 20));
			default: sl = 18'($urandom_range(need, 18'h3FFFF));
		endcase
		if (pk == PK_HASHED_OVR) begin
			h = $urandom_range(1, 16'hFFFF);
			sl = 18'($urandom_range(MIN_SIG_LEN, h + MIN_SIG_LEN - 1));
		end else if (pk == PK_UNHASH_OVR) begin
			u = $urandom_range(1, 16'hFFFF);
			sl = 18'($urandom_range(MIN_SIG_LEN + h, MIN_SIG_LEN + h + u - 1));
		end
		if (pk == PK_SHORT) begin
			add_word(rnd8(), 1'b1, 18'($urandom_range(0, MIN_SIG_LEN - 1)));
		end else begin
			add_word(rnd8(), 1'b1, sl);
			add_body(rnd8());
			add_body(rnd8());
			add_body(h[15:8]);
			add_body(h[7:0]);
			if (pk != PK_HASHED_OVR) begin
				repeat (h) add_body(rnd8());
				add_body(u[15:8]);
				add_body(u[7:0]);
				if (pk != PK_UNHASH_OVR) begin
					foreach (area_bytes[i]) add_body(area_bytes[i]);
					add_body(rnd8());
					add_body(rnd8());
				end
			end
		end
		if (pk == PK_ABANDON)
			commit($urandom_range(1, pkt_words.size() - 1), 1'b1, drain);
		else
			commit(pkt_words.size(), 1'b1, drain);
	endtask

	initial begin
		pkt_kind_t pk;
		area_kind_t ak;
		int unsigned roll;
		bit drain, mid_done;
		reset_parse();

		// boundary packets
		add_word(8'hFF, 1'b1, 18'd0);
		add_word(8'h00, 1'b1, MIN_SIG_LEN - 1);
		add_word(8'h00, 1'b1, 18'd65544);
		add_body(8'hFF);
		add_body(8'h00);
		add_body(8'hFF);
		add_body(8'hFF);
		add_word(8'hFF, 1'b1, 18'd65544);
		add_body(8'h00);
		add_body(8'hFF);
		add_body(8'h00);
		add_body(8'h00);
		add_body(8'hFF);
		add_body(8'hFF);
		add_word(8'h13, 1'b1, 18'h3FFFF);
		add_body(8'h01);
		add_body(8'h08);
		repeat (4) add_body(8'h00);
		add_body(8'hFF);
		add_body(8'hFF);
		commit(pkt_words.size(), 1'b1, 1'b0);

		drain = 1'b1;
		mid_done = 1'b0;
		while (stim_count < WORDS_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) pk = PK_SHORT;
			else if (roll < 12) pk = PK_HASHED_OVR;
			else if (roll < 18) pk = PK_UNHASH_OVR;
			else if (roll < 28) pk = PK_ABANDON;
			else pk = PK_NORMAL;
			if ($urandom_range(0, 99) < 55)
				ak = AK_GOOD;
			else
				ak = area_kind_t'($urandom_range(AK_NOISE, AK_EMPTY));
			if (!mid_done && stim_count >= WORDS_TARGET / 2) begin
				drain = 1'b1;
				mid_done = 1'b1;
			end
			gen_packet(pk, ak, drain);
			drain = 1'b0;
			if (pk != PK_ABANDON && $urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) add_body(rnd8());
				commit(pkt_words.size(), 1'b0, 1'b0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (tx_words.size() != 0 || s_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("openpgp_sig_v4_parser verification clean");
		end else begin
			$display("openpgp_sig_v4_parser verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("openpgp_sig_v4_parser verification failed");
		$finish;
	end

	// driver
	byte_word_t    cur;
	opsig_result_t pred;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid <= 1'b0;
		end else begin
			if (s_valid && s_ready) begin
				if (parse_word(cur.data, cur.first, cur.len, pred))
					predicted_results.push_back(pred);
			end
			if (!s_valid || s_ready) begin
				if (tx_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)
						&& !(tx_words[0].wait_drain && predicted_results.size() != 0)) begin
					cur = tx_words.pop_front();
					s_valid <= 1'b1;
					s_tdata <= {6'd0, cur.len, cur.data};
					s_tuser <= cur.first;
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			m_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			if (cyc == HOLD_AT) hold_left <= HOLD_LEN;
			m_ready <= quiet || ($urandom_range(0, 99) >= 8);
		end
	end

	task automatic log_mismatch(input string what, input opsig_result_t want,
			input opsig_result_t seen);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("%s: expected st %0d rd %0d type %h pk %h dg %h hl %h ul %h hc %h id %h",
				what, want.status, want.bytes_read, want.sig_type, want.pubkey_algo,
				want.hash_algo, want.hashed_len, want.unhashed_len, want.hash_check,
				want.issuer_id);
			$display("%s: actual   st %0d rd %0d type %h pk %h dg %h hl %h ul %h hc %h id %h",
				what, seen.status, seen.bytes_read, seen.sig_type, seen.pubkey_algo,
				seen.hash_algo, seen.hashed_len, seen.unhashed_len, seen.hash_check,
				seen.issuer_id);
		end
	endtask

	// monitor
	opsig_result_t seen, want;

	always @(posedge clk) begin
		if (arst_n && m_valid && m_ready) begin
			seen = opsig_result_t'(m_tdata[RES_W-1:0]);
			if (predicted_results.size() == 0) begin
				log_mismatch("unexpected result", '0, seen);
			end else begin
				want = predicted_results.pop_front();
				if (seen.status !== want.status || seen.bytes_read !== want.bytes_read
						|| seen.sig_type !== want.sig_type
						|| seen.pubkey_algo !== want.pubkey_algo
						|| seen.hash_algo !== want.hash_algo
						|| seen.hashed_len !== want.hashed_len
						|| seen.unhashed_len !== want.unhashed_len
						|| seen.hash_check !== want.hash_check
						|| seen.issuer_id !== want.issuer_id)
					log_mismatch("result mismatch", want, seen);
			end
		end
	end

endmodule

`default_nettype wire

// File: files.f
design/opsig_pkg.sv
design/opsig_core.sv
design/openpgp_sig_v4_parser.sv
tb/openpgp_sig_v4_parser_tb.sv
